/* src/pfn_pkg.sv */
// ----------------------------------------------------------------------------
// pfn_pkg: shared definitions for the fbm gradient noise block
// widths, command and register codes, gradient helper
// ----------------------------------------------------------------------------
package pfn_pkg;

    localparam int TABLE_SIZE  = 256;
    localparam int MAX_OCTAVES = 16;

    localparam int TBL_AW     = $clog2(TABLE_SIZE);
    localparam int OCT_W      = $clog2(MAX_OCTAVES + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int COORD_W    = 32;
    localparam int SUM_W      = 21;
    localparam int FREQ_W     = 40;
    localparam int AMP_W      = 17;
    localparam int OCTCFG_W   = 5;
    localparam int LAC_W      = 24;
    localparam int PERS_W     = 17;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [AMP_W-1:0] AMP_MAX = {AMP_W{1'b1}};
    localparam logic [FREQ_W-1:0] FREQ_ONE = 40'd65536;
    localparam logic [AMP_W-1:0]  AMP_ONE  = 17'd65536;

    // command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LACUNARITY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERSISTENCE  = 2'd2;

    // improved noise gradient: +-u +-v picked by the low hash bits
    function automatic logic signed [19:0] grad(input logic [3:0] h,
                                                input logic signed [17:0] x,
                                                input logic signed [17:0] y,
                                                input logic signed [17:0] z);
        logic signed [17:0] u;
        logic signed [17:0] v;
        logic signed [19:0] su;
        logic signed [19:0] sv;
        u = (h < 4'd8) ? x : y;
        if (h < 4'd4) begin
            v = y;
        end else if (h inside {4'd12, 4'd14}) begin
            v = x;
        end else begin
            v = z;
        end
        su = h[0] ? -20'(u) : 20'(u);
        sv = h[1] ? -20'(v) : 20'(v);
        return su + sv;
    endfunction

endpackage

/* src/pfn_if.sv */
// ----------------------------------------------------------------------------
// pfn_if: stream and register channels of the noise block
// valid/ready bundles with source and sink views
// ----------------------------------------------------------------------------
interface pfn_in_if;
    logic                               valid;
    logic                               ready;
    logic                               cmd;
    logic [7:0]                         table_index;
    logic [7:0]                         table_value;
    logic signed [pfn_pkg::COORD_W-1:0] coord_x;
    logic signed [pfn_pkg::COORD_W-1:0] coord_y;
    logic signed [pfn_pkg::COORD_W-1:0] coord_z;

    modport source (output valid, cmd, table_index, table_value, coord_x, coord_y, coord_z,
                    input ready);
    modport sink (input valid, cmd, table_index, table_value, coord_x, coord_y, coord_z,
                  output ready);
endinterface

interface pfn_out_if;
    logic                       valid;
    logic                       ready;
    logic [pfn_pkg::SUM_W-1:0]  noise_sum;

    modport source (output valid, noise_sum, input ready);
    modport sink (input valid, noise_sum, output ready);
endinterface

interface pfn_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [pfn_pkg::CFG_IDX_W-1:0]   index;
    logic [pfn_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* src/pfn_ram.sv */
// ----------------------------------------------------------------------------
// pfn_ram: generic single-write, single-read ram
// one write port, registered read port
// ----------------------------------------------------------------------------
module pfn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/perlin_fbm_noise.sv */
// ----------------------------------------------------------------------------
// perlin_fbm_noise: 3d improved gradient noise summed over octaves
// fixed-point fbm evaluator around one shared multiplier and a table ram
// ----------------------------------------------------------------------------
// A load transfer (cmd 0) writes one entry of the 256-entry permutation table;
// every entry must be loaded before the first evaluation. An evaluate transfer
// (cmd 1) takes a signed Q16.16 point and returns one unsigned Q5.16 sum. The
// input is ready only while the block is idle. Each octave runs its steps in
// turn on the single shared 33x33 multiplier, which takes every product
// (scaling, fade, lerp, weighting and the frequency and amplitude updates),
// with the table reads overlapped on the fade steps. The sum of
// min(octave_count, 16) octaves is loaded into the output register as soon as
// that register is free, and the input is ready again after that; an octave
// count of zero answers zero. Register writes are always ready and take effect
// at once; write them only while idle.
// ----------------------------------------------------------------------------
module perlin_fbm_noise (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pfn_in_if.sink        i_in,
    pfn_out_if.source     o_out,
    pfn_cfg_if.sink       i_cfg
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIN
    } t_state;

    // one step per cycle of an octave
    typedef enum logic [5:0] {
        ST_SC_XL, ST_SC_XH, ST_SC_YL, ST_SC_YH, ST_SC_ZL, ST_SC_ZH, ST_SC_END,
        ST_FX_SQ, ST_FX_CUBE, ST_FX_INNER, ST_FX_MIX, ST_FX_END,
        ST_FY_SQ, ST_FY_CUBE, ST_FY_INNER, ST_FY_MIX, ST_FY_END,
        ST_FZ_SQ, ST_FZ_CUBE, ST_FZ_INNER, ST_FZ_MIX, ST_FZ_END,
        ST_L_A, ST_L_B, ST_L_C, ST_L_D, ST_L_E, ST_L_F, ST_L_G, ST_L_H, ST_L_END,
        ST_AC_MUL, ST_AC_SUM, ST_AMP_UPD, ST_FQ_LO, ST_FQ_END
    } t_step;

    // configuration registers
    logic [pfn_pkg::OCTCFG_W-1:0] r_octave_count;
    logic [pfn_pkg::LAC_W-1:0]    r_lacunarity;
    logic [pfn_pkg::PERS_W-1:0]   r_persistence;

    // control
    t_state                      r_state;
    t_step                       r_step;
    logic [pfn_pkg::OCT_W-1:0]   r_oct;
    logic [pfn_pkg::OCT_W-1:0]   r_noct;
    logic                        r_out_valid;
    logic [pfn_pkg::SUM_W-1:0]   r_out_sum;

    // datapath
    logic signed [pfn_pkg::COORD_W-1:0] r_cx, r_cy, r_cz;
    logic [pfn_pkg::FREQ_W-1:0] r_freq;
    logic [pfn_pkg::AMP_W-1:0]  r_amp;
    logic [pfn_pkg::SUM_W-1:0]  r_sum;
    logic [64:0]                r_acc;
    logic [23:0]                r_sx, r_sy, r_sz;
    logic [16:0]                r_t3;
    logic [16:0]                r_u, r_v, r_w;
    logic [7:0]                 r_pa, r_b, r_aa, r_ab, r_ba, r_bb;
    logic [3:0]                 r_h [8];
    logic signed [19:0]         r_l1, r_l2, r_l3, r_l4, r_l5, r_l6;
    logic [16:0]                r_val;
    logic signed [65:0]         r_prod;

    logic                       w_in_xfer;
    logic                       w_ram_we;
    logic [pfn_pkg::TBL_AW-1:0] w_rd_addr;
    logic [7:0]                 w_q;
    logic signed [32:0]         w_mul_a, w_mul_b;
    logic [15:0]                w_t;
    logic signed [32:0]         w_six;
    logic signed [17:0]         w_x0, w_y0, w_z0, w_x1, w_y1, w_z1;
    logic signed [19:0]         w_g [8];
    logic signed [20:0]         w_diff;
    logic signed [19:0]         w_da, w_db;
    logic signed [21:0]         w_lq;
    logic signed [19:0]         w_lbase;
    logic signed [21:0]         w_lres;
    logic signed [22:0]         w_vraw;
    logic [16:0]                w_val;
    logic signed [49:0]         w_fr;
    logic [16:0]                w_fade;
    logic [21:0]                w_sum22;
    logic [17:0]                w_amp18;
    logic [64:0]                w_ftot;
    logic [39:0]                w_s40;
    logic [pfn_pkg::OCT_W-1:0]  w_noct;
    logic [pfn_pkg::FREQ_W-1:0] w_freq_nx;

    assign w_in_xfer = i_in.valid && i_in.ready;
    assign w_ram_we  = w_in_xfer && (i_in.cmd == pfn_pkg::CMD_LOAD);
    assign i_in.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.noise_sum = r_out_sum;

    // octave count limited to the supported maximum
    assign w_noct = (32'(r_octave_count) > pfn_pkg::MAX_OCTAVES)
                  ? pfn_pkg::OCT_W'(pfn_pkg::MAX_OCTAVES)
                  : pfn_pkg::OCT_W'(r_octave_count);

    // register writes; unknown indexes fall through
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octave_count <= 5'd1;
            r_lacunarity   <= 24'd131072;
            r_persistence  <= 17'd32768;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                pfn_pkg::CFG_OCTAVE_COUNT: r_octave_count <= i_cfg.data[4:0];
                pfn_pkg::CFG_LACUNARITY:   r_lacunarity   <= i_cfg.data[23:0];
                pfn_pkg::CFG_PERSISTENCE:  r_persistence  <= i_cfg.data[16:0];
                default: ;
            endcase
        end
    end

    // permutation table
    pfn_ram #(
        .WIDTH (8),
        .DEPTH (pfn_pkg::TABLE_SIZE)
    ) u_perm (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (i_in.table_index),
        .i_wdata (i_in.table_value),
        .i_raddr (w_rd_addr),
        .o_rdata (w_q)
    );

    // corner offsets f and f - 1 in Q.16
    assign w_x0 = {2'b00, r_sx[15:0]};
    assign w_y0 = {2'b00, r_sy[15:0]};
    assign w_z0 = {2'b00, r_sz[15:0]};
    assign w_x1 = w_x0 - 18'sd65536;
    assign w_y1 = w_y0 - 18'sd65536;
    assign w_z1 = w_z0 - 18'sd65536;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            w_g[k] = pfn_pkg::grad(r_h[k], k[0] ? w_x1 : w_x0, k[1] ? w_y1 : w_y0,
                                   k[2] ? w_z1 : w_z0);
        end
    end

    // fraction under fade for the current axis
    always_comb begin
        case (r_step)
            ST_FY_SQ, ST_FY_CUBE, ST_FY_INNER, ST_FY_MIX, ST_FY_END: w_t = r_sy[15:0];
            ST_FZ_SQ, ST_FZ_CUBE, ST_FZ_INNER, ST_FZ_MIX, ST_FZ_END: w_t = r_sz[15:0];
            default: w_t = r_sx[15:0];
        endcase
    end

    // 6t - 15.0, wraps into a signed word
    assign w_six = 33'({w_t, 2'b00}) + 33'({w_t, 1'b0}) - 33'd983040;

    // lerp operands and base
    always_comb begin
        w_da = w_g[0];
        w_db = w_g[1];
        w_lbase = r_l3;
        case (r_step)
            ST_L_A: begin w_da = w_g[0]; w_db = w_g[1]; end
            ST_L_B: begin w_da = w_g[2]; w_db = w_g[3]; w_lbase = w_g[0]; end
            ST_L_C: begin w_da = w_g[4]; w_db = w_g[5]; w_lbase = w_g[2]; end
            ST_L_D: begin w_da = w_g[6]; w_db = w_g[7]; w_lbase = w_g[4]; end
            ST_L_E: begin w_da = r_l1; w_db = r_l2; w_lbase = w_g[6]; end
            ST_L_F: begin w_da = r_l4; w_db = r_l5; w_lbase = r_l1; end
            ST_L_G: begin w_lbase = r_l4; end
            ST_L_H: begin w_da = r_l3; w_db = r_l6; end
            default: ;
        endcase
    end

    assign w_diff = 21'(w_db) - 21'(w_da);
    assign w_lq   = r_prod[37:16];
    assign w_lres = 22'(w_lbase) + w_lq;

    // octave value 0.5 + n/2 clamped to [0, 1]
    assign w_vraw = 23'sd32768 + 23'(w_lres >>> 1);
    assign w_val  = (w_vraw < 0) ? 17'd0
                  : (w_vraw > 23'sd65536) ? 17'd65536 : w_vraw[16:0];

    // fade result capped to [0, 1]
    assign w_fr   = r_prod[65:16];
    assign w_fade = (w_fr > 50'sd65536) ? 17'd65536
                  : (w_fr < 0) ? 17'd0 : w_fr[16:0];

    assign w_sum22 = {1'b0, r_sum} + {4'b0000, r_prod[33:16]};
    assign w_amp18 = r_prod[33:16];
    assign w_ftot  = r_acc + {r_prod[44:0], 20'd0};
    assign w_s40   = r_acc[39:0] + {r_prod[19:0], 20'd0};
    assign w_freq_nx = (w_ftot[64:56] != 9'd0) ? {pfn_pkg::FREQ_W{1'b1}} : w_ftot[55:16];

    // shared multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_step)
            ST_SC_XL: begin w_mul_a = {r_cx[31], r_cx}; w_mul_b = {13'd0, r_freq[19:0]}; end
            ST_SC_XH: begin w_mul_a = {r_cx[31], r_cx}; w_mul_b = {13'd0, r_freq[39:20]}; end
            ST_SC_YL: begin w_mul_a = {r_cy[31], r_cy}; w_mul_b = {13'd0, r_freq[19:0]}; end
            ST_SC_YH: begin w_mul_a = {r_cy[31], r_cy}; w_mul_b = {13'd0, r_freq[39:20]}; end
            ST_SC_ZL: begin w_mul_a = {r_cz[31], r_cz}; w_mul_b = {13'd0, r_freq[19:0]}; end
            ST_SC_ZH: begin w_mul_a = {r_cz[31], r_cz}; w_mul_b = {13'd0, r_freq[39:20]}; end
            ST_FX_SQ, ST_FY_SQ, ST_FZ_SQ: begin
                w_mul_a = {17'd0, w_t};
                w_mul_b = {17'd0, w_t};
            end
            ST_FX_CUBE, ST_FY_CUBE, ST_FZ_CUBE: begin
                w_mul_a = r_prod[48:16];
                w_mul_b = {17'd0, w_t};
            end
            ST_FX_INNER, ST_FY_INNER, ST_FZ_INNER: begin
                w_mul_a = {17'd0, w_t};
                w_mul_b = w_six;
            end
            ST_FX_MIX, ST_FY_MIX, ST_FZ_MIX: begin
                w_mul_a = {16'd0, r_t3};
                w_mul_b = r_prod[48:16] + 33'sd655360;
            end
            ST_L_A, ST_L_B, ST_L_C, ST_L_D: begin
                w_mul_a = {16'd0, r_u};
                w_mul_b = 33'(w_diff);
            end
            ST_L_E, ST_L_F: begin
                w_mul_a = {16'd0, r_v};
                w_mul_b = 33'(w_diff);
            end
            ST_L_H: begin
                w_mul_a = {16'd0, r_w};
                w_mul_b = 33'(w_diff);
            end
            ST_AC_MUL: begin w_mul_a = {16'd0, r_val}; w_mul_b = {16'd0, r_amp}; end
            ST_AC_SUM: begin w_mul_a = {16'd0, r_amp}; w_mul_b = {16'd0, r_persistence}; end
            ST_AMP_UPD: begin
                w_mul_a = {13'd0, r_freq[19:0]};
                w_mul_b = {9'd0, r_lacunarity};
            end
            ST_FQ_LO: begin
                w_mul_a = {13'd0, r_freq[39:20]};
                w_mul_b = {9'd0, r_lacunarity};
            end
            default: ;
        endcase
    end

    // table read address, data comes back one step later
    always_comb begin
        case (r_step)
            ST_FX_SQ:    w_rd_addr = r_sx[23:16];
            ST_FX_CUBE:  w_rd_addr = r_sx[23:16] + 8'd1;
            ST_FX_INNER: w_rd_addr = r_pa + r_sy[23:16];
            ST_FX_MIX:   w_rd_addr = r_pa + r_sy[23:16] + 8'd1;
            ST_FX_END:   w_rd_addr = r_b;
            ST_FY_SQ:    w_rd_addr = r_b + 8'd1;
            ST_FY_CUBE:  w_rd_addr = r_aa;
            ST_FY_INNER: w_rd_addr = r_ba;
            ST_FY_MIX:   w_rd_addr = r_ab;
            ST_FY_END:   w_rd_addr = r_bb;
            ST_FZ_SQ:    w_rd_addr = r_aa + 8'd1;
            ST_FZ_CUBE:  w_rd_addr = r_ba + 8'd1;
            ST_FZ_INNER: w_rd_addr = r_ab + 8'd1;
            ST_FZ_MIX:   w_rd_addr = r_bb + 8'd1;
            default:     w_rd_addr = r_sx[23:16];
        endcase
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= ST_SC_XL;
            r_oct       <= '0;
            r_noct      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // the finish state reloads the output register itself
            if (o_out.valid && o_out.ready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer && i_in.cmd == pfn_pkg::CMD_EVAL) begin
                        r_step <= ST_SC_XL;
                        r_oct  <= '0;
                        r_noct <= w_noct;
                        // zero octaves go straight to the answer
                        r_state <= (w_noct == '0) ? S_FIN : S_RUN;
                    end
                end
                S_RUN: begin
                    if (r_step == ST_FQ_END) begin
                        r_step <= ST_SC_XL;
                        r_oct  <= r_oct + 1'b1;
                        if (r_oct + 1'b1 == r_noct) begin
                            r_state <= S_FIN;
                        end
                    end else begin
                        r_step <= t_step'(r_step + 6'd1);
                    end
                end
                S_FIN: begin
                    // wait for the output register to free up
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_sum   <= r_sum;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        if (r_state == S_IDLE) begin
            if (w_in_xfer) begin
                r_cx   <= i_in.coord_x;
                r_cy   <= i_in.coord_y;
                r_cz   <= i_in.coord_z;
                r_freq <= pfn_pkg::FREQ_ONE;
                r_amp  <= pfn_pkg::AMP_ONE;
                r_sum  <= '0;
            end
        end else if (r_state == S_RUN) begin
            case (r_step)
                ST_SC_XH, ST_SC_YH, ST_SC_ZH: r_acc <= r_prod[64:0];
                ST_SC_YL:    r_sx <= w_s40[39:16];
                ST_SC_ZL:    r_sy <= w_s40[39:16];
                ST_SC_END:   r_sz <= w_s40[39:16];
                ST_FX_CUBE:  r_pa <= w_q;
                ST_FX_INNER: begin
                    r_t3 <= r_prod[32:16];
                    r_b  <= w_q + r_sy[23:16];
                end
                ST_FX_MIX:   r_aa <= w_q + r_sz[23:16];
                ST_FX_END: begin
                    r_u  <= w_fade;
                    r_ab <= w_q + r_sz[23:16];
                end
                ST_FY_SQ:    r_ba <= w_q + r_sz[23:16];
                ST_FY_CUBE:  r_bb <= w_q + r_sz[23:16];
                ST_FY_INNER: begin
                    r_t3   <= r_prod[32:16];
                    r_h[0] <= w_q[3:0];
                end
                ST_FY_MIX:   r_h[1] <= w_q[3:0];
                ST_FY_END: begin
                    r_v    <= w_fade;
                    r_h[2] <= w_q[3:0];
                end
                ST_FZ_SQ:    r_h[3] <= w_q[3:0];
                ST_FZ_CUBE:  r_h[4] <= w_q[3:0];
                ST_FZ_INNER: begin
                    r_t3   <= r_prod[32:16];
                    r_h[5] <= w_q[3:0];
                end
                ST_FZ_MIX:   r_h[6] <= w_q[3:0];
                ST_FZ_END: begin
                    r_w    <= w_fade;
                    r_h[7] <= w_q[3:0];
                end
                ST_L_B:      r_l1 <= w_lres[19:0];
                ST_L_C:      r_l2 <= w_lres[19:0];
                ST_L_D:      r_l4 <= w_lres[19:0];
                ST_L_E:      r_l5 <= w_lres[19:0];
                ST_L_F:      r_l3 <= w_lres[19:0];
                ST_L_G:      r_l6 <= w_lres[19:0];
                ST_L_END:    r_val <= w_val;
                ST_AC_SUM:   r_sum <= (w_sum22 > 22'(pfn_pkg::SUM_MAX))
                                      ? pfn_pkg::SUM_MAX : w_sum22[20:0];
                ST_AMP_UPD:  r_amp <= w_amp18[17] ? pfn_pkg::AMP_MAX : w_amp18[16:0];
                ST_FQ_LO:    r_acc <= r_prod[64:0];
                ST_FQ_END:   r_freq <= w_freq_nx;
                default: ;
            endcase
        end
    end

    // an evaluate transfer always leaves idle
    a_eval_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && i_in.cmd == pfn_pkg::CMD_EVAL) |=> (r_state != S_IDLE))
        else $error("evaluate transfer did not start work");

    // octave counter stays below its limit while running
    a_oct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_oct < r_noct))
        else $error("octave counter past limit");

    // results appear only out of the finish state
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_FIN))
        else $error("result raised outside finish");

    // no table write while an evaluation reads it
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> !w_ram_we)
        else $error("table written during evaluation");

    // last octave update hands over to the finish state
    a_last_octave: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_step == ST_FQ_END && (r_oct + 1'b1) == r_noct)
        |=> (r_state == S_FIN))
        else $error("sequencer missed the last octave");

endmodule
